// ----- rtl/nvtm_pkg.sv -----
`timescale 1ns / 1ps

package nvtm_pkg;

  // Store geometry
  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Coordinate and distance widths (signed Q11.8 points, Q.16 squared distances)
  localparam int COORD_W = 20;
  localparam int PT_W    = 3 * COORD_W;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MAG_W   = COORD_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int DIST_W  = 42;

  // Tolerance register
  localparam int                TOL_W     = DIST_W;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(655);

  // Request encoding
  localparam int                ACT_W      = 2;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam int                ACT_QUERY_BIT = 1;

  // Command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  localparam int STATUS_W = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_APPEND,
    CMD_QUERY
  } cmd_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CLEARED  = 3'd0,
    ST_APPENDED = 3'd1,
    ST_FULL     = 3'd2,
    ST_MATCHED  = 3'd3,
    ST_NO_MATCH = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_FINISH
  } back_state_t;

  typedef struct packed {
    cmd_kind_t kind;
    coord_t    x;
    coord_t    y;
    coord_t    z;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] dist_sq;
    coord_t            hx;
    coord_t            hy;
    coord_t            hz;
    logic [CNT_W-1:0]  held;
  } res_t;

endpackage

// ----- rtl/nvtm_ram.sv -----
`timescale 1ns / 1ps

module nvtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/nvtm_front.sv -----
`timescale 1ns / 1ps

module nvtm_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [nvtm_pkg::ACT_W-1:0]   action,
  input  nvtm_pkg::coord_t             pos_x,
  input  nvtm_pkg::coord_t             pos_y,
  input  nvtm_pkg::coord_t             pos_z,
  output logic                         cmd_valid,
  input  logic                         cmd_pop,
  output nvtm_pkg::cmd_t               cmd
);

  import nvtm_pkg::*;

  cmd_t                slot [CQ_DEPTH];
  cmd_t                decoded;
  logic [CQ_PTR_W-1:0] wr_ptr;
  logic [CQ_PTR_W-1:0] rd_ptr;
  logic [CQ_CNT_W-1:0] fill;
  logic [CQ_CNT_W-1:0] fill_next;
  logic                accept;
  logic                take;

  // Only bit 1 picks a query, so the unused code also queries.
  always_comb begin
    decoded.x = pos_x;
    decoded.y = pos_y;
    decoded.z = pos_z;
    if (action[ACT_QUERY_BIT]) begin
      decoded.kind = CMD_QUERY;
    end else if (action == ACT_APPEND) begin
      decoded.kind = CMD_APPEND;
    end else begin
      decoded.kind = CMD_CLEAR;
    end
  end

  assign full      = (fill == CQ_CNT_W'(CQ_DEPTH));
  assign cmd_valid = (fill != '0);
  assign cmd       = slot[rd_ptr];
  assign accept    = push && !full;
  assign take      = cmd_pop && cmd_valid;

  always_comb begin
    fill_next = fill;
    if (accept && !take) begin
      fill_next = fill + CQ_CNT_W'(1);
    end else if (take && !accept) begin
      fill_next = fill - CQ_CNT_W'(1);
    end
  end

  // Pointers wrap by overflow: the queue depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (accept) begin
        wr_ptr <= wr_ptr + CQ_PTR_W'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + CQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[wr_ptr] <= decoded;
    end
  end

endmodule

// ----- rtl/nvtm_back.sv -----
`timescale 1ns / 1ps

module nvtm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  nvtm_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  input  logic [nvtm_pkg::TOL_W-1:0]  tol_sq,
  output logic                        res_valid,
  input  logic                        res_pop,
  output nvtm_pkg::res_t              res
);

  import nvtm_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  scan_addr;
  logic              last_addr;
  logic              start_scan;
  logic              issue;
  logic              finish;
  logic              append_ok;
  coord_t            qpos [3];

  logic [PT_W-1:0]   rdata;

  // Distance pipeline
  logic              v1, v2, v3, v4;
  logic              last1, last2, last3, last4;
  logic [IDX_W-1:0]  idx1, idx2, idx3, idx4;
  logic [PT_W-1:0]   pt2, pt3, pt4;
  logic [DIFF_W-1:0] diff [3];
  logic [MAG_W-1:0]  mag2 [3];
  logic [SQ_W-1:0]   sq3 [3];
  logic [DIST_W-1:0] dist4;

  // Running best
  logic              best_ok;
  logic [DIST_W-1:0] best_d;
  logic [IDX_W-1:0]  best_idx;
  logic [PT_W-1:0]   best_pt;
  logic              take_best;

  res_t              res_next;
  logic              res_load;

  nvtm_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (append_ok),
    .waddr (count[IDX_W-1:0]),
    .wdata ({cmd.z, cmd.y, cmd.x}),
    .raddr (scan_addr),
    .rdata (rdata)
  );

  assign last_addr = ((CNT_W'(scan_addr) + CNT_W'(1)) == count);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (start_scan) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (last_addr) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (v4 && last4) begin
          state_next = BK_FINISH;
        end
      end
      BK_FINISH: state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop    = (state == BK_IDLE) && cmd_valid && !res_valid;
    start_scan = cmd_pop && (cmd.kind == CMD_QUERY) && (count != '0);
    append_ok  = cmd_pop && (cmd.kind == CMD_APPEND) && (count < CNT_W'(MAX_POINTS));
    issue      = (state == BK_SCAN);
    finish     = (state == BK_FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan address and query position
  always_ff @(posedge clk) begin
    if (start_scan) begin
      scan_addr <= '0;
      qpos[0]   <= cmd.x;
      qpos[1]   <= cmd.y;
      qpos[2]   <= cmd.z;
    end else if (issue) begin
      scan_addr <= scan_addr + IDX_W'(1);
    end
  end

  // Stage 1: read data returns; stage 2: absolute differences
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = {qpos[k][COORD_W-1], qpos[k]}
              - {rdata[k*COORD_W + COORD_W-1], rdata[k*COORD_W +: COORD_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    last1 <= last_addr;
    idx1  <= scan_addr;
    last2 <= last1;
    idx2  <= idx1;
    pt2   <= rdata;
    for (int k = 0; k < 3; k++) begin
      mag2[k] <= diff[k][DIFF_W-1] ? MAG_W'(-diff[k]) : MAG_W'(diff[k]);
    end
    // Stage 3: squares
    last3 <= last2;
    idx3  <= idx2;
    pt3   <= pt2;
    for (int k = 0; k < 3; k++) begin
      sq3[k] <= SQ_W'(mag2[k]) * SQ_W'(mag2[k]);
    end
    // Stage 4: sum
    last4 <= last3;
    idx4  <= idx3;
    pt4   <= pt3;
    dist4 <= DIST_W'(sq3[0]) + DIST_W'(sq3[1]) + DIST_W'(sq3[2]);
  end

  // Strictly smaller replaces, so the earliest point wins a tie.
  assign take_best = v4 && (!best_ok || (dist4 < best_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      best_ok <= 1'b0;
    end else if (start_scan) begin
      best_ok <= 1'b0;
    end else if (v4) begin
      best_ok <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_best) begin
      best_d   <= dist4;
      best_idx <= idx4;
      best_pt  <= pt4;
    end
  end

  always_comb begin
    res_next      = '0;
    res_next.held = count;
    res_load      = 1'b0;
    if (finish) begin
      res_load       = 1'b1;
      res_next.status = (best_d <= tol_sq) ? ST_MATCHED : ST_NO_MATCH;
      res_next.index = best_idx;
      res_next.dist_sq = best_d;
      res_next.hx    = best_pt[0 +: COORD_W];
      res_next.hy    = best_pt[COORD_W +: COORD_W];
      res_next.hz    = best_pt[2*COORD_W +: COORD_W];
    end else if (cmd_pop && !start_scan) begin
      res_load = 1'b1;
      case (cmd.kind)
        CMD_CLEAR: begin
          res_next.status = ST_CLEARED;
          res_next.held   = '0;
        end
        CMD_APPEND: begin
          if (append_ok) begin
            res_next.status = ST_APPENDED;
            res_next.index  = count[IDX_W-1:0];
            res_next.hx     = cmd.x;
            res_next.hy     = cmd.y;
            res_next.hz     = cmd.z;
            res_next.held   = count + CNT_W'(1);
          end else begin
            res_next.status = ST_FULL;
          end
        end
        default: res_next.status = ST_EMPTY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        count     <= res_next.held;
        res_valid <= 1'b1;
      end else if (res_pop && res_valid) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule

// ----- rtl/nearest_vertex_tolerance_match.sv -----
`timescale 1ns / 1ps

// Nearest-point matcher over a store of up to 1024 points in signed Q11.8.
// Each request clears the store, appends one point or queries a position; each
// gives exactly one result, in request order. A query compares the squared
// distance (Q.16) of every stored point in index order, keeps the first
// smallest and reports match when it is at most tolerance_sq (reset 655, about
// 0.1 squared). Requests enter a two-deep command queue, so push keeps working
// while a result waits on the output. A query over N stored points is paced by
// the single read port of the point memory, which the back end sweeps one point
// per cycle into a four-stage difference, square and sum pipeline. tolerance_sq
// is written through cfg_valid/cfg_ready (always ready) and should only change
// while idle.
module nearest_vertex_tolerance_match (
  input  logic                          clk,
  input  logic                          rst,
  // Request side
  input  logic                          push,
  output logic                          full,
  input  logic [nvtm_pkg::ACT_W-1:0]    action,
  input  logic signed [nvtm_pkg::COORD_W-1:0] pos_x,
  input  logic signed [nvtm_pkg::COORD_W-1:0] pos_y,
  input  logic signed [nvtm_pkg::COORD_W-1:0] pos_z,
  // Result side
  output logic                          empty,
  input  logic                          pop,
  output logic [nvtm_pkg::STATUS_W-1:0] status,
  output logic [nvtm_pkg::IDX_W-1:0]    nearest_index,
  output logic [nvtm_pkg::DIST_W-1:0]   nearest_dist_sq,
  output logic signed [nvtm_pkg::COORD_W-1:0] hint_x,
  output logic signed [nvtm_pkg::COORD_W-1:0] hint_y,
  output logic signed [nvtm_pkg::COORD_W-1:0] hint_z,
  output logic [nvtm_pkg::CNT_W-1:0]    points_held,
  // Configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nvtm_pkg::TOL_W-1:0]    tolerance_sq
);

  import nvtm_pkg::*;

  logic             cmd_valid;
  logic             cmd_pop;
  cmd_t             cmd;
  logic [TOL_W-1:0] tol_sq;
  logic             res_valid;
  res_t             res;

  // Tolerance register; the port never stalls a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol_sq <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tol_sq <= tolerance_sq;
    end
  end

  // Front end: decode the request and hold it in the command queue.
  nvtm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .action    (action),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  // Back end: own the store and count, run the scan, hold the result.
  nvtm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .tol_sq    (tol_sq),
    .res_valid (res_valid),
    .res_pop   (pop),
    .res       (res)
  );

  assign empty           = !res_valid;
  assign status          = res.status;
  assign nearest_index   = res.index;
  assign nearest_dist_sq = res.dist_sq;
  assign hint_x          = res.hx;
  assign hint_y          = res.hy;
  assign hint_z          = res.hz;
  assign points_held     = res.held;

endmodule

// ----- rtl/nvtm_checker.sv -----
`timescale 1ns / 1ps

module nvtm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          empty,
  input logic                          pop,
  input logic [nvtm_pkg::STATUS_W-1:0] status,
  input logic [nvtm_pkg::IDX_W-1:0]    nearest_index,
  input logic [nvtm_pkg::DIST_W-1:0]   nearest_dist_sq,
  input logic [nvtm_pkg::CNT_W-1:0]    points_held
);

  import nvtm_pkg::*;

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    !empty |-> points_held <= CNT_W'(MAX_POINTS))
    else $error("points_held beyond store size");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_CLEARED) |->
      (points_held == '0 && nearest_index == '0 && nearest_dist_sq == '0))
    else $error("clear result not zeroed");

  a_append_slot: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_APPENDED) |->
      (CNT_W'(nearest_index) + CNT_W'(1) == points_held))
    else $error("append slot does not match count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_FULL) |-> points_held == CNT_W'(MAX_POINTS))
    else $error("store full reported below capacity");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(nearest_dist_sq)))
    else $error("waiting result changed");

endmodule

bind nearest_vertex_tolerance_match nvtm_checker u_nvtm_checker (.*);
